@@ hdl/knn_heom_pkg.sv @@
// Package: shared constants, types and codes for the k-nearest-neighbor HEOM classifier.
package knn_heom_pkg;

    localparam int MAX_EXAMPLES  = 1024;
    localparam int MAX_FEATURES  = 64;
    localparam int MAX_NEIGHBORS = 16;

    localparam int EX_W    = $clog2(MAX_EXAMPLES);
    localparam int TOTAL_W = $clog2(MAX_EXAMPLES + 1);
    localparam int COL_W   = $clog2(MAX_FEATURES);
    localparam int FCNT_W  = $clog2(MAX_FEATURES + 1);
    localparam int SLOT_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int KCNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int FADDR_W = EX_W + COL_W;

    localparam int VAL_W   = 16;
    localparam int ENTRY_W = VAL_W + 1;
    localparam int DIST_W  = 38;
    localparam int SUM_W   = VAL_W + KCNT_W;
    localparam int DIVC_W  = $clog2(SUM_W + 1);
    localparam int CFG_W   = 64;

    localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1) << 24;

    typedef logic [COL_W-1:0]        col_t;
    typedef logic [FCNT_W-1:0]       fcnt_t;
    typedef logic [EX_W-1:0]         ex_idx_t;
    typedef logic [TOTAL_W-1:0]      total_t;
    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [KCNT_W-1:0]       kcnt_t;
    typedef logic [ENTRY_W-1:0]      entry_t;
    typedef logic [DIST_W-1:0]       dist_t;
    typedef logic [MAX_FEATURES-1:0] mask_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_FULL = 2'd2,
        STATUS_RSVD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_K       = 2'd0,
        REG_CONT    = 2'd1,
        REG_NOMINAL = 2'd2,
        REG_FCOUNT  = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_KEEP,
        S_FAR,
        S_FETCH_A,
        S_FETCH_D,
        S_SUM,
        S_DIV,
        S_VOTE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    start;
        ex_idx_t row;
    } dist_req_t;

    typedef struct packed {
        logic  done;
        dist_t sq_sum;
    } dist_rsp_t;

    typedef struct packed {
        logic                 we;
        logic [FADDR_W-1:0]   addr;
        entry_t               data;
    } feat_wr_t;

    typedef struct packed {
        logic   we;
        col_t   addr;
        entry_t data;
    } qry_wr_t;

endpackage

@@ hdl/knn_dist_unit.sv @@
// Distance unit: feature stores and a pipelined per-column HEOM accumulator.
module knn_dist_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  knn_heom_pkg::dist_req_t req,
    input  knn_heom_pkg::fcnt_t     f_eff,
    input  knn_heom_pkg::mask_t     mask,
    input  knn_heom_pkg::feat_wr_t  fwr,
    input  knn_heom_pkg::qry_wr_t   qwr,
    output knn_heom_pkg::dist_rsp_t rsp
);
    import knn_heom_pkg::*;

    entry_t ex_mem [MAX_EXAMPLES*MAX_FEATURES];
    entry_t q_mem  [MAX_FEATURES];

    logic    active_reg;
    fcnt_t   iss_col_reg;
    ex_idx_t row_reg;
    entry_t  ex_q_reg, qf_q_reg;
    logic    s1_vld_reg, s1_last_reg;
    col_t    s1_col_reg;
    dist_t   term_reg;
    logic    s2_vld_reg, s2_last_reg;
    dist_t   acc_reg;
    logic    done_reg;
    dist_t   sq_sum_reg;

    logic               iss_last;
    logic [FADDR_W-1:0] raddr;
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] sq;
    dist_t              term_next;

    assign iss_last = (iss_col_reg + fcnt_t'(1)) >= f_eff;
    assign raddr    = {row_reg, iss_col_reg[COL_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (fwr.we)
        begin
            ex_mem[fwr.addr] <= fwr.data;
        end
        if (qwr.we)
        begin
            q_mem[qwr.addr] <= qwr.data;
        end
        ex_q_reg <= ex_mem[raddr];
        qf_q_reg <= q_mem[iss_col_reg[COL_W-1:0]];
    end

    assign diff = $signed({ex_q_reg[VAL_W-1], ex_q_reg[VAL_W-1:0]})
                - $signed({qf_q_reg[VAL_W-1], qf_q_reg[VAL_W-1:0]});
    assign sq   = diff * diff;

    always_comb
    begin
        if (ex_q_reg[VAL_W] || qf_q_reg[VAL_W])
        begin
            term_next = DIST_ONE;
        end
        else if (mask[s1_col_reg])
        begin
            term_next = (ex_q_reg[VAL_W-1:0] != qf_q_reg[VAL_W-1:0]) ? DIST_ONE : '0;
        end
        else
        begin
            term_next = DIST_W'(unsigned'(sq));
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        if (req.start)
        begin
            row_reg <= req.row;
        end
        s1_col_reg <= iss_col_reg[COL_W-1:0];
        sq_sum_reg <= acc_reg + term_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            iss_col_reg  <= '0;
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                active_reg  <= 1'b1;
                iss_col_reg <= '0;
            end
            else if (active_reg)
            begin
                iss_col_reg <= iss_col_reg + fcnt_t'(1);
                if (iss_last)
                begin
                    active_reg <= 1'b0;
                end
            end
            s1_vld_reg   <= active_reg && !req.start;
            s1_last_reg  <= active_reg && !req.start && iss_last;
            s2_vld_reg   <= s1_vld_reg;
            s2_last_reg  <= s1_last_reg;
            done_reg     <= s2_vld_reg && s2_last_reg;
            if (s2_vld_reg)
            begin
                acc_reg <= s2_last_reg ? '0 : acc_reg + term_reg;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.sq_sum = sq_sum_reg;

endmodule

@@ hdl/knn_heom_classifier.sv @@
// Top level: k-nearest-neighbor HEOM classifier with sequencer, neighbor list, voting and mean.
// Loads, clears and non-final query items are accepted in S_IDLE; an error result also passes S_RESULT.
// A final query item walks all N stored rows, computing each distance and rescanning for the
// farthest neighbor whenever the full list has changed, then fetches the K neighbor labels
// and votes or takes their mean unless one is at distance zero. in_ready is low meanwhile.
// rst_n is asynchronous: control, counters and configuration reset; stores are undefined.
module knn_heom_classifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic signed [15:0] feature_value,
    input  logic        feature_unknown,
    input  logic signed [15:0] example_label,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] prediction,
    output logic        exact_match,
    output logic [1:0]  status,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import knn_heom_pkg::*;

    logic [4:0]  k_cfg_reg;
    logic        cont_reg;
    mask_t       mask_reg;
    logic [6:0]  fcfg_reg;

    state_t state_reg, state_next;
    total_t total_reg, total_next;
    col_t   pos_reg, pos_next;
    kcnt_t  filled_reg, filled_next;
    ex_idx_t row_reg, row_next;
    dist_t  cand_reg, cand_next;
    logic   far_ok_reg, far_ok_next;
    slot_t  far_slot_reg, far_slot_next;
    dist_t  far_d_reg, far_d_next;
    ex_idx_t far_i_reg, far_i_next;
    kcnt_t  s_reg, s_next;
    logic   hz_reg, hz_next;
    slot_t  zslot_reg, zslot_next;
    ex_idx_t zrow_reg, zrow_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic   neg_reg, neg_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [KCNT_W-1:0] rem_reg, rem_next;
    logic [DIVC_W-1:0] divc_reg, divc_next;
    kcnt_t  best_cnt_reg, best_cnt_next;
    logic signed [VAL_W-1:0] best_lab_reg, best_lab_next;
    logic signed [VAL_W-1:0] res_pred_reg, res_pred_next;
    logic   res_exact_reg, res_exact_next;
    status_t res_status_reg, res_status_next;
    logic   start_reg, start_next;

    dist_t   nd_reg [MAX_NEIGHBORS];
    dist_t   nd_next [MAX_NEIGHBORS];
    ex_idx_t ni_reg [MAX_NEIGHBORS];
    ex_idx_t ni_next [MAX_NEIGHBORS];
    logic signed [VAL_W-1:0] lab_reg [MAX_NEIGHBORS];
    logic signed [VAL_W-1:0] lab_next [MAX_NEIGHBORS];

    logic        out_valid_reg;
    logic signed [VAL_W-1:0] pred_reg;
    logic        exact_reg;
    status_t     status_reg;

    logic [VAL_W-1:0] lab_mem [MAX_EXAMPLES];
    logic [VAL_W-1:0] lab_q;
    logic        lab_we;
    ex_idx_t     lab_waddr, lab_raddr;

    kcnt_t  k_eff;
    fcnt_t  f_eff;
    logic   accept, pos_last, full;
    entry_t entry;
    slot_t  s_slot;
    feat_wr_t fwr;
    qry_wr_t  qwr;
    dist_req_t dreq;
    dist_rsp_t drsp;
    logic [MAX_NEIGHBORS-1:0] eq_vec;
    kcnt_t  vote_cnt;
    logic [KCNT_W:0] rem_sh;
    logic [SUM_W-1:0] sum_mag;

    assign k_eff = (k_cfg_reg == 5'd0) ? kcnt_t'(1)
                 : (KCNT_W'(k_cfg_reg) > kcnt_t'(MAX_NEIGHBORS) || k_cfg_reg > 5'(MAX_NEIGHBORS))
                   ? kcnt_t'(MAX_NEIGHBORS) : KCNT_W'(k_cfg_reg);
    assign f_eff = (fcfg_reg == 7'd0) ? fcnt_t'(1)
                 : (fcfg_reg > 7'(MAX_FEATURES)) ? fcnt_t'(MAX_FEATURES) : FCNT_W'(fcfg_reg);

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign pos_last = (FCNT_W'(pos_reg) + fcnt_t'(1)) >= f_eff;
    assign full     = total_reg >= total_t'(MAX_EXAMPLES);
    assign entry    = {feature_unknown, feature_value};
    assign s_slot   = s_reg[SLOT_W-1:0];

    assign dreq.start = start_reg;
    assign dreq.row   = row_reg;

    assign fwr.we   = accept && (op_t'(operation) == OP_LOAD) && !full;
    assign fwr.addr = {total_reg[EX_W-1:0], pos_reg};
    assign fwr.data = entry;
    assign qwr.we   = accept && (op_t'(operation) == OP_QUERY);
    assign qwr.addr = pos_reg;
    assign qwr.data = entry;

    assign lab_we    = accept && (op_t'(operation) == OP_LOAD) && pos_last && !full;
    assign lab_waddr = total_reg[EX_W-1:0];
    assign lab_raddr = ni_reg[s_slot];

    knn_dist_unit u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .f_eff (f_eff),
        .mask  (mask_reg),
        .fwr   (fwr),
        .qwr   (qwr),
        .rsp   (drsp)
    );

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_waddr] <= example_label;
        end
        lab_q <= lab_mem[lab_raddr];
    end

    always_comb
    begin
        for (int t = 0; t < MAX_NEIGHBORS; t++)
        begin
            eq_vec[t] = (kcnt_t'(t) < filled_reg) && (lab_reg[t] == lab_reg[s_slot]);
        end
        vote_cnt = KCNT_W'($countones(eq_vec));
    end

    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        filled_next     = filled_reg;
        row_next        = row_reg;
        cand_next       = cand_reg;
        far_ok_next     = far_ok_reg;
        far_slot_next   = far_slot_reg;
        far_d_next      = far_d_reg;
        far_i_next      = far_i_reg;
        s_next          = s_reg;
        hz_next         = hz_reg;
        zslot_next      = zslot_reg;
        zrow_next       = zrow_reg;
        sum_next        = sum_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        divc_next       = divc_reg;
        best_cnt_next   = best_cnt_reg;
        best_lab_next   = best_lab_reg;
        res_pred_next   = res_pred_reg;
        res_exact_next  = res_exact_reg;
        res_status_next = res_status_reg;
        start_next      = 1'b0;
        nd_next         = nd_reg;
        ni_next         = ni_reg;
        lab_next        = lab_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(operation))
                        OP_LOAD:
                        begin
                            pos_next = pos_last ? '0 : pos_reg + col_t'(1);
                            if (pos_last)
                            begin
                                if (full)
                                begin
                                    res_pred_next   = '0;
                                    res_exact_next  = 1'b0;
                                    res_status_next = STATUS_FULL;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    total_next = total_reg + total_t'(1);
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            pos_next = pos_last ? '0 : pos_reg + col_t'(1);
                            if (pos_last)
                            begin
                                if (total_reg < TOTAL_W'(k_eff))
                                begin
                                    res_pred_next   = '0;
                                    res_exact_next  = 1'b0;
                                    res_status_next = STATUS_FEW;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    filled_next = '0;
                                    far_ok_next = 1'b0;
                                    row_next    = '0;
                                    start_next  = 1'b1;
                                    state_next  = S_DIST;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            total_next  = '0;
                            pos_next    = '0;
                            filled_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIST:
            begin
                if (drsp.done)
                begin
                    cand_next  = drsp.sq_sum;
                    state_next = S_KEEP;
                end
            end
            S_KEEP:
            begin
                if (filled_reg < k_eff || far_ok_reg)
                begin
                    if (filled_reg < k_eff)
                    begin
                        nd_next[filled_reg[SLOT_W-1:0]] = cand_reg;
                        ni_next[filled_reg[SLOT_W-1:0]] = row_reg;
                        filled_next = filled_reg + kcnt_t'(1);
                        far_ok_next = 1'b0;
                    end
                    else if (far_d_reg > cand_reg)
                    begin
                        nd_next[far_slot_reg] = cand_reg;
                        ni_next[far_slot_reg] = row_reg;
                        far_ok_next = 1'b0;
                    end
                    if ((TOTAL_W'(row_reg) + total_t'(1)) >= total_reg)
                    begin
                        s_next     = '0;
                        hz_next    = 1'b0;
                        state_next = S_FETCH_A;
                    end
                    else
                    begin
                        row_next   = row_reg + ex_idx_t'(1);
                        start_next = 1'b1;
                        state_next = S_DIST;
                    end
                end
                else
                begin
                    far_slot_next = '0;
                    far_d_next    = nd_reg[0];
                    far_i_next    = ni_reg[0];
                    s_next        = kcnt_t'(1);
                    state_next    = S_FAR;
                end
            end
            S_FAR:
            begin
                if (s_reg < filled_reg)
                begin
                    if (nd_reg[s_slot] > far_d_reg ||
                        (nd_reg[s_slot] == far_d_reg && ni_reg[s_slot] > far_i_reg))
                    begin
                        far_slot_next = s_slot;
                        far_d_next    = nd_reg[s_slot];
                        far_i_next    = ni_reg[s_slot];
                    end
                    s_next = s_reg + kcnt_t'(1);
                end
                else
                begin
                    far_ok_next = 1'b1;
                    state_next  = S_KEEP;
                end
            end
            S_FETCH_A:
            begin
                if (s_reg < filled_reg)
                begin
                    state_next = S_FETCH_D;
                end
                else if (hz_reg)
                begin
                    res_pred_next   = lab_reg[zslot_reg];
                    res_exact_next  = 1'b1;
                    res_status_next = STATUS_OK;
                    state_next      = S_RESULT;
                end
                else if (cont_reg)
                begin
                    s_next     = '0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    s_next        = '0;
                    best_cnt_next = '0;
                    best_lab_next = '0;
                    state_next    = S_VOTE;
                end
            end
            S_FETCH_D:
            begin
                lab_next[s_slot] = lab_q;
                if (nd_reg[s_slot] == '0 && (!hz_reg || ni_reg[s_slot] < zrow_reg))
                begin
                    hz_next    = 1'b1;
                    zslot_next = s_slot;
                    zrow_next  = ni_reg[s_slot];
                end
                s_next     = s_reg + kcnt_t'(1);
                state_next = S_FETCH_A;
            end
            S_SUM:
            begin
                if (s_reg < filled_reg)
                begin
                    sum_next = sum_reg + SUM_W'(lab_reg[s_slot]);
                    s_next   = s_reg + kcnt_t'(1);
                end
                else
                begin
                    neg_next   = sum_reg[SUM_W-1];
                    quo_next   = sum_mag;
                    rem_next   = '0;
                    divc_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (divc_reg < DIVC_W'(SUM_W))
                begin
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                    if (rem_sh >= {1'b0, k_eff})
                    begin
                        rem_next    = KCNT_W'(rem_sh - {1'b0, k_eff});
                        quo_next[0] = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_sh[KCNT_W-1:0];
                    end
                    divc_next = divc_reg + DIVC_W'(1);
                end
                else
                begin
                    res_pred_next   = neg_reg ? VAL_W'(-quo_reg) : VAL_W'(quo_reg);
                    res_exact_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    state_next      = S_RESULT;
                end
            end
            S_VOTE:
            begin
                if (s_reg < filled_reg)
                begin
                    if (vote_cnt > best_cnt_reg ||
                        (vote_cnt == best_cnt_reg && lab_reg[s_slot] < best_lab_reg))
                    begin
                        best_cnt_next = vote_cnt;
                        best_lab_next = lab_reg[s_slot];
                    end
                    s_next = s_reg + kcnt_t'(1);
                end
                else
                begin
                    res_pred_next   = best_lab_reg;
                    res_exact_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg     <= 5'd5;
            cont_reg      <= 1'b0;
            mask_reg      <= '0;
            fcfg_reg      <= 7'd1;
            total_reg     <= '0;
            pos_reg       <= '0;
            filled_reg    <= '0;
            far_ok_reg    <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_K:       k_cfg_reg <= cfg_data[4:0];
                    REG_CONT:    cont_reg  <= cfg_data[0];
                    REG_NOMINAL: mask_reg  <= cfg_data[MAX_FEATURES-1:0];
                    REG_FCOUNT:  fcfg_reg  <= cfg_data[6:0];
                    default:     k_cfg_reg <= k_cfg_reg;
                endcase
            end
            total_reg  <= total_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
            far_ok_reg <= far_ok_next;
            start_reg  <= start_next;
            if (state_reg == S_RESULT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        cand_reg       <= cand_next;
        far_slot_reg   <= far_slot_next;
        far_d_reg      <= far_d_next;
        far_i_reg      <= far_i_next;
        s_reg          <= s_next;
        hz_reg         <= hz_next;
        zslot_reg      <= zslot_next;
        zrow_reg       <= zrow_next;
        sum_reg        <= sum_next;
        neg_reg        <= neg_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        divc_reg       <= divc_next;
        best_cnt_reg   <= best_cnt_next;
        best_lab_reg   <= best_lab_next;
        res_pred_reg   <= res_pred_next;
        res_exact_reg  <= res_exact_next;
        res_status_reg <= res_status_next;
        nd_reg         <= nd_next;
        ni_reg         <= ni_next;
        lab_reg        <= lab_next;
        if (state_reg == S_RESULT && (!out_valid_reg || out_ready))
        begin
            pred_reg   <= res_pred_reg;
            exact_reg  <= res_exact_reg;
            status_reg <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prediction  = pred_reg;
    assign exact_match = exact_reg;
    assign status      = status_reg;

endmodule

@@ hdl/knn_heom_checker.sv @@
// Port checker for the classifier, bound to the top level.
module knn_heom_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [15:0] prediction,
    input logic        exact_match,
    input logic [1:0]  status
);
    import knn_heom_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prediction) && $stable(status))
        else $error("result changed while stalled");

    a_exact_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exact_match |-> status == STATUS_OK)
        else $error("exact match with error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> prediction == 16'sd0 && !exact_match)
        else $error("error result carries data");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != STATUS_RSVD)
        else $error("reserved status");

endmodule

bind knn_heom_classifier knn_heom_checker u_knn_heom_checker (.*);
